>>> rtl/mlp_inference_engine_core_macros.svh
// ----------------------------------------------------------------------------
// mlp_inference_engine_core_macros.svh
// Assertion macros used by the inference engine core.
// ----------------------------------------------------------------------------
`ifndef MLP_INFERENCE_ENGINE_CORE_MACROS_SVH
`define MLP_INFERENCE_ENGINE_CORE_MACROS_SVH

// Check an expression on every clock edge out of reset.
`define MLPI_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mlpi assertion failed");

// Check that an antecedent implies a consequent in the following cycle.
`define MLPI_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlpi assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define MLPI_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlpi assertion failed");

`endif

>>> rtl/mlpi_pkg.sv
// ----------------------------------------------------------------------------
// mlpi_pkg
// Types, constants and arithmetic helpers of the inference engine.
// ----------------------------------------------------------------------------
package mlpi_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int ACC_BITS    = 56;
	localparam int MAX_LAYERS  = 4;
	localparam int MAX_WIDTH   = 64;
	localparam int MAX_OUTPUTS = 8;
	localparam int LAYER_W     = 2;
	localparam int IDX_W       = 6;
	localparam int CLASS_W     = 3;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;

	// input item kinds
	localparam logic [2:0] OP_WEIGHT  = 3'd0;
	localparam logic [2:0] OP_BIAS    = 3'd1;
	localparam logic [2:0] OP_MEAN    = 3'd2;
	localparam logic [2:0] OP_INVDEV  = 3'd3;
	localparam logic [2:0] OP_FEATURE = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_TASK_MODE    = 3'd0;
	localparam logic [2:0] REG_LAYER_COUNT  = 3'd1;
	localparam logic [2:0] REG_INPUT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_HIDDEN_ONE   = 3'd3;
	localparam logic [2:0] REG_HIDDEN_TWO   = 3'd4;
	localparam logic [2:0] REG_HIDDEN_THREE = 3'd5;
	localparam logic [2:0] REG_OUTPUT_WIDTH = 3'd6;

	// hard sigmoid knots and levels, Q16.16
	localparam value_t SIG_NEG4  = -32'sd262144;
	localparam value_t SIG_NEG2  = -32'sd131072;
	localparam value_t SIG_POS2  = 32'sd131072;
	localparam value_t SIG_POS4  = 32'sd262144;
	localparam value_t SIG_QUART = 32'sd16384;
	localparam value_t SIG_HALF  = 32'sd32768;
	localparam value_t SIG_3QUART = 32'sd49152;
	localparam value_t SIG_ONE   = 32'sd65536;

	localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
	localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

	// control that rides along with one multiply term
	typedef struct packed {
		logic             valid;
		logic             norm;
		logic             use_term;
		logic             first;
		logic             last;
		logic             relu;
		logic [IDX_W-1:0] idx;
	} tag_t;

	// write of one finished value into the cell row
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		value_t           data;
	} wr_t;

	function automatic value_t sat_value(input acc_t v);
		value_t r;
		if (v > SAT_HI) begin
			r = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else if (v < SAT_LO) begin
			r = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			r = v[VALUE_BITS-1:0];
		end
		return r;
	endfunction

	function automatic value_t hard_sigmoid(input value_t x);
		value_t r;
		if (x <= SIG_NEG4) begin
			r = '0;
		end else if (x <= SIG_NEG2) begin
			r = (x >>> 4) + SIG_QUART;
		end else if (x <= SIG_POS2) begin
			r = (x >>> 3) + SIG_HALF;
		end else if (x <= SIG_POS4) begin
			r = (x >>> 4) + SIG_3QUART;
		end else begin
			r = SIG_ONE;
		end
		return r;
	endfunction

endpackage

>>> rtl/mlp_inference_engine_core.sv
// ----------------------------------------------------------------------------
// mlp_inference_engine_core
// Fixed-point MLP inference over a ring of activation cells.
// ----------------------------------------------------------------------------
// Channel    Dir  Beat contents
// s_axis     in   tuser: op; tdata: layer, row, col, value
// m_axis     out  tdata: predicted_class, score
// cfg        in   cfg_index selects register, cfg_data is written
//
// Load beats and features that do not close a vector are taken while idle.
// The closing feature starts inference: a copy, a normalize pass over all
// 64 slots, one pass per layer over 64 input slots per output neuron, a drain
// after each pass, then argmax over up to 8 outputs; one MAC pipeline serves all.
// Reset clears control and sets configuration to defaults; stores are undefined until loaded.
// A held result does not block loads; a new result waits in ST_OUT for the slot.
// ----------------------------------------------------------------------------
module mlp_inference_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,   // op
	input  logic [47:0] s_axis_tdata,   // layer, row, col, value, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // predicted_class, score, zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import mlpi_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_COPY   = 3'd1;
	localparam logic [2:0] ST_NORM   = 3'd2;
	localparam logic [2:0] ST_DENSE  = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_ARGMAX = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	// configuration
	logic       task_mode_q;
	logic [2:0] layer_count_q;
	logic [6:0] input_width_q;
	logic [6:0] hidden_one_q;
	logic [6:0] hidden_two_q;
	logic [6:0] hidden_three_q;
	logic [3:0] output_width_q;

	// sequencer
	logic [2:0]         state_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   j_q;
	logic [LAYER_W-1:0] layer_q;
	logic [2:0]         am_q;
	logic               norm_phase_q;
	value_t             best_q;
	logic [CLASS_W-1:0] best_idx_q;

	// output slot
	logic               m_valid_q;
	logic [CLASS_W-1:0] out_class_q;
	value_t             out_score_q;

	// stores
	value_t weight_mem [MAX_LAYERS*MAX_WIDTH*MAX_WIDTH];
	value_t bias_mem   [MAX_LAYERS*MAX_WIDTH];
	value_t mean_mem   [MAX_WIDTH];
	value_t invdev_mem [MAX_WIDTH];

	// first pipeline stage
	tag_t   tag_s1;
	value_t head_s1;
	value_t weight_s1;
	value_t bias_s1;
	value_t mean_s1;
	value_t invdev_s1;

	wr_t    wr;
	logic   dp_busy;
	value_t cur [MAX_WIDTH];

	// beat fields
	logic [2:0]         in_op;
	logic [LAYER_W-1:0] in_layer;
	logic [IDX_W-1:0]   in_row;
	logic [IDX_W-1:0]   in_col;
	value_t             in_value;
	logic               in_acc;
	logic               trigger;

	// clamped sizes
	logic [2:0] nl;
	logic [6:0] in_w;
	logic [6:0] hid_c [MAX_LAYERS];
	logic [3:0] out_w;
	logic       last_layer;
	logic [6:0] n_in;
	logic [6:0] n_out;
	logic [3:0] n_final;
	logic       drained;
	value_t     head;
	value_t     sig;

	assign in_op    = s_axis_tuser;
	assign in_layer = s_axis_tdata[1:0];
	assign in_row   = s_axis_tdata[7:2];
	assign in_col   = s_axis_tdata[13:8];
	assign in_value = s_axis_tdata[45:14];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	function automatic logic [6:0] clamp_w(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > 7'd64) begin
			r = 7'd64;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_comb begin
		if (layer_count_q == 3'd0) begin
			nl = 3'd1;
		end else if (layer_count_q > 3'd4) begin
			nl = 3'd4;
		end else begin
			nl = layer_count_q;
		end
		if (output_width_q == 4'd0) begin
			out_w = 4'd1;
		end else if (output_width_q > 4'd8) begin
			out_w = 4'd8;
		end else begin
			out_w = output_width_q;
		end
	end

	assign in_w     = clamp_w(input_width_q);
	assign hid_c[0] = clamp_w(hidden_one_q);
	assign hid_c[1] = clamp_w(hidden_two_q);
	assign hid_c[2] = clamp_w(hidden_three_q);
	assign hid_c[3] = 7'd64;

	assign last_layer = ({1'b0, layer_q} + 3'd1) == nl;
	assign n_in       = (layer_q == '0) ? in_w : hid_c[layer_q - 2'd1];
	assign n_out      = last_layer ? {3'b000, out_w} : hid_c[layer_q];
	assign n_final    = task_mode_q ? out_w : 4'd1;
	assign trigger    = (in_op == OP_FEATURE) && (({1'b0, in_row} + 7'd1) == in_w);
	assign drained    = !tag_s1.valid && !dp_busy;
	assign head       = cur[0];
	assign sig        = hard_sigmoid(best_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_mode_q    <= 1'b0;
			layer_count_q  <= 3'd2;
			input_width_q  <= 7'd16;
			hidden_one_q   <= 7'd16;
			hidden_two_q   <= 7'd16;
			hidden_three_q <= 7'd16;
			output_width_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TASK_MODE:    task_mode_q    <= cfg_data[0];
				REG_LAYER_COUNT:  layer_count_q  <= cfg_data[2:0];
				REG_INPUT_WIDTH:  input_width_q  <= cfg_data;
				REG_HIDDEN_ONE:   hidden_one_q   <= cfg_data;
				REG_HIDDEN_TWO:   hidden_two_q   <= cfg_data;
				REG_HIDDEN_THREE: hidden_three_q <= cfg_data;
				REG_OUTPUT_WIDTH: output_width_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// store writes from load beats, registered reads for the MAC pipeline
	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_WEIGHT) begin
			weight_mem[{in_layer, in_row, in_col}] <= in_value;
		end
		if (in_acc && in_op == OP_BIAS) begin
			bias_mem[{in_layer, in_col}] <= in_value;
		end
		if (in_acc && in_op == OP_MEAN) begin
			mean_mem[in_row] <= in_value;
		end
		if (in_acc && in_op == OP_INVDEV) begin
			invdev_mem[in_row] <= in_value;
		end
		weight_s1 <= weight_mem[{layer_q, k_q, j_q}];
		bias_s1   <= bias_mem[{layer_q, j_q}];
		mean_s1   <= mean_mem[k_q];
		invdev_s1 <= invdev_mem[k_q];
		head_s1   <= head;
	end

	// issue one term per cycle while normalizing or running a layer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid    <= (state_q == ST_NORM) || (state_q == ST_DENSE);
			tag_s1.norm     <= (state_q == ST_NORM);
			tag_s1.use_term <= ({1'b0, k_q} < n_in);
			tag_s1.first    <= (k_q == '0);
			tag_s1.last     <= &k_q;
			tag_s1.relu     <= !last_layer;
			tag_s1.idx      <= (state_q == ST_NORM) ? k_q : j_q;
		end
	end

	mlpi_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.head_s1   (head_s1),
		.mean_s1   (mean_s1),
		.invdev_s1 (invdev_s1),
		.weight_s1 (weight_s1),
		.bias      (bias_s1),
		.wr        (wr),
		.busy      (dp_busy)
	);

	// ring of cells: rotate toward cell 0, which feeds the pipeline
	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		mlpi_cell u_cell (
			.clk      (clk),
			.raw_we   (in_acc && in_op == OP_FEATURE && in_row == IDX_W'(i)),
			.raw_d    (in_value),
			.load     (state_q == ST_COPY),
			.shift    (state_q == ST_NORM || state_q == ST_DENSE || state_q == ST_ARGMAX),
			.shift_in (cur[(i + 1) % MAX_WIDTH]),
			.nxt_we   (wr.we && wr.idx == IDX_W'(i)),
			.nxt_d    (wr.data),
			.commit   (state_q == ST_DRAIN && drained),
			.cur      (cur[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= '0;
			j_q          <= '0;
			layer_q      <= '0;
			am_q         <= '0;
			norm_phase_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			// drop the taken beat unless a new one replaces it below
			if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && trigger) begin
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					k_q          <= '0;
					norm_phase_q <= 1'b1;
					state_q      <= ST_NORM;
				end
				ST_NORM: begin
					k_q <= k_q + 1'b1;
					if (&k_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DENSE: begin
					k_q <= k_q + 1'b1;
					if (&k_q) begin
						if ({1'b0, j_q} + 7'd1 == n_out) begin
							state_q <= ST_DRAIN;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						k_q <= '0;
						j_q <= '0;
						am_q <= '0;
						if (norm_phase_q) begin
							norm_phase_q <= 1'b0;
							layer_q      <= '0;
							state_q      <= ST_DENSE;
						end else if (last_layer) begin
							state_q <= ST_ARGMAX;
						end else begin
							layer_q <= layer_q + 1'b1;
							state_q <= ST_DENSE;
						end
					end
				end
				ST_ARGMAX: begin
					// first index wins a tie
					if (am_q == '0 || head > best_q) begin
						best_q     <= head;
						best_idx_q <= am_q;
					end
					am_q <= am_q + 1'b1;
					if ({1'b0, am_q} + 4'd1 == n_final) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload, loaded when the slot frees
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
			if (task_mode_q) begin
				out_class_q <= best_idx_q;
				out_score_q <= best_q;
			end else begin
				out_class_q <= (sig >= SIG_HALF) ? CLASS_W'(1) : CLASS_W'(0);
				out_score_q <= sig;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b00000, out_score_q, out_class_q};

`include "mlp_inference_engine_core_macros.svh"

	`MLPI_ASSERT_IMPLY(a_ready_when_drained, s_axis_tready, !tag_s1.valid && !dp_busy)
	`MLPI_ASSERT_IMPLY(a_write_in_pass, wr.we,
		state_q == ST_NORM || state_q == ST_DENSE || state_q == ST_DRAIN)
	`MLPI_ASSERT_NEXT(a_out_waits, state_q == ST_OUT && m_valid_q && !m_axis_tready,
		state_q == ST_OUT)

endmodule

>>> rtl/mlpi_cell.sv
// ----------------------------------------------------------------------------
// mlpi_cell
// One cell of the activation ring: raw feature, working value, next value.
// ----------------------------------------------------------------------------
module mlpi_cell (
	input  logic             clk,
	input  logic             raw_we,
	input  mlpi_pkg::value_t raw_d,
	input  logic             load,
	input  logic             shift,
	input  mlpi_pkg::value_t shift_in,
	input  logic             nxt_we,
	input  mlpi_pkg::value_t nxt_d,
	input  logic             commit,
	output mlpi_pkg::value_t cur
);
	import mlpi_pkg::*;

	value_t raw_q;
	value_t cur_q;
	value_t nxt_q;

	always_ff @(posedge clk) begin
		if (raw_we) begin
			raw_q <= raw_d;
		end
		if (load) begin
			cur_q <= raw_q;
		end else if (shift) begin
			cur_q <= shift_in;
		end else if (commit) begin
			cur_q <= nxt_q;
		end
		if (nxt_we) begin
			nxt_q <= nxt_d;
		end
	end

	assign cur = cur_q;

endmodule

>>> rtl/mlpi_datapath.sv
// ----------------------------------------------------------------------------
// mlpi_datapath
// Operand select, multiply, round and accumulate for one term per cycle.
// ----------------------------------------------------------------------------
module mlpi_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  mlpi_pkg::tag_t   tag_s1,
	input  mlpi_pkg::value_t head_s1,
	input  mlpi_pkg::value_t mean_s1,
	input  mlpi_pkg::value_t invdev_s1,
	input  mlpi_pkg::value_t weight_s1,
	input  mlpi_pkg::value_t bias,
	output mlpi_pkg::wr_t    wr,
	output logic             busy
);
	import mlpi_pkg::*;

	tag_t                    tag_s2;
	tag_t                    tag_s3;
	value_t                  a_s2;
	value_t                  b_s2;
	logic signed [63:0]      prod_s3;
	acc_t                    acc_q;
	acc_t                    diff;
	logic signed [63:0]      rnd_full;
	acc_t                    rnd;
	acc_t                    term;
	acc_t                    acc_sum;
	value_t                  neuron;

	assign diff = acc_t'(head_s1) - acc_t'(mean_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s2    <= tag_s1.norm ? sat_value(diff) : head_s1;
		b_s2    <= tag_s1.norm ? invdev_s1 : weight_s1;
		prod_s3 <= 64'(a_s2) * 64'(b_s2);
		if (tag_s3.valid && !tag_s3.norm) begin
			acc_q <= acc_sum;
		end
	end

	// round to nearest, ties up, then floor shift
	assign rnd_full = (prod_s3 + 64'sd32768) >>> 16;
	assign rnd      = rnd_full[ACC_BITS-1:0];
	assign term     = tag_s3.use_term ? rnd : '0;
	assign acc_sum  = (tag_s3.first ? acc_t'(bias) : acc_q) + term;
	assign neuron   = sat_value(acc_sum);

	always_comb begin
		wr.we   = tag_s3.valid && (tag_s3.norm || tag_s3.last);
		wr.idx  = tag_s3.idx;
		if (tag_s3.norm) begin
			wr.data = sat_value(rnd);
		end else if (tag_s3.relu && neuron[VALUE_BITS-1]) begin
			wr.data = '0;
		end else begin
			wr.data = neuron;
		end
	end

	assign busy = tag_s2.valid || tag_s3.valid;

endmodule
